/* src/npws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npws_pkg: shared types for the nearest point on wall segments block
// Holds the input and result item structs, the wall entry type and widths.
// ----------------------------------------------------------------------------
package npws_pkg;

	localparam int unsigned DefMaxWalls = 64;
	localparam int unsigned CoordW      = 16;
	localparam int unsigned DistW       = 33;
	localparam int unsigned NumWallsW   = 7;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic              func;
		logic [5:0]        wall_index;
		logic signed [15:0] wall_x1;
		logic signed [15:0] wall_y1;
		logic signed [15:0] wall_x2;
		logic signed [15:0] wall_y2;
		logic signed [15:0] query_x;
		logic signed [15:0] query_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] closest_x;
		logic signed [15:0] closest_y;
		logic [32:0]        dist_sq;
		logic [5:0]         nearest_wall;
		logic               found;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
	} wall_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_query;   // latch query point, clear best
		logic read_data;    // read data valid: capture wall
		logic step_diff;    // compute delta and offsets
		logic step_prod;    // products for len_sq and dot
		logic step_sum;     // sum products
		logic div_start;    // start divider
		logic step_tmul;    // t times delta
		logic step_point;   // form point and errors
		logic step_esq;     // squares of errors
		logic step_cmp;     // distance and compare
	} npws_cmd_t;

	typedef struct packed {
		logic div_done;
	} npws_sts_t;

endpackage

`default_nettype wire

/* src/nearest_point_on_wall_segments.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_on_wall_segments: nearest point on a table of wall segments
// Wall writes load the table; a query returns the nearest projected point.
//
//   Channel  Signals                     Handshake
//   input    start, busy, in_item        taken when start && !busy
//   result   done, out_item              one cycle strobe, no back pressure
//   config   cfg_valid, cfg_ready, cfg_data  write when valid && ready
//
// A wall write gives no result. A query holds busy while the walls are
// searched one at a time, each through the 49-step divider, and strobes done
// in the cycle after. A wall whose projection clamps at the far end, or a
// degenerate wall, saturates the divider at once. Reset empties no table;
// num_walls resets to zero. The result port cannot be stalled.
// ----------------------------------------------------------------------------
module nearest_point_on_wall_segments
	import npws_pkg::*;
#(
	parameter int unsigned MaxWalls = DefMaxWalls
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             in_item,
	output logic                      done,
	output out_item_t                 out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [NumWallsW-1:0] cfg_data
);

	localparam int unsigned AddrW = $clog2(MaxWalls);
	localparam int unsigned IdxW  = $clog2(MaxWalls + 1);

	logic [NumWallsW-1:0] num_walls_q;
	npws_cmd_t            cmd;
	npws_sts_t            sts;
	logic [IdxW-1:0]      idx;
	logic                 ctrl_busy;
	logic                 wr_en;
	logic                 go;
	wall_t                wdata, rdata;

	assign cfg_ready = 1'b1;
	assign busy      = ctrl_busy;
	assign go        = start && !ctrl_busy && (in_item.func == FUNC_QUERY);
	assign wr_en     = start && !ctrl_busy && (in_item.func == FUNC_WRITE)
	                   && (32'(in_item.wall_index) < MaxWalls);
	assign wdata     = '{in_item.wall_x1, in_item.wall_y1, in_item.wall_x2,
	                     in_item.wall_y2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_walls_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			num_walls_q <= cfg_data;
		end
	end

	npws_ram #(.Width($bits(wall_t)), .Depth(MaxWalls)) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(AddrW'(in_item.wall_index)),
		.wdata(wdata),
		.raddr(idx[AddrW-1:0]),
		.rdata(rdata)
	);

	npws_ctrl #(.MaxWalls(MaxWalls)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.num_walls(num_walls_q),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx),
		.busy     (ctrl_busy),
		.done     (done)
	);

	npws_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wall_idx(6'(idx)),
		.qx_in   (in_item.query_x),
		.qy_in   (in_item.query_y),
		.rdata   (rdata),
		.sts     (sts),
		.best    (out_item)
	);

`ifndef SYNTHESIS
	a_done_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a query");
	a_notfound_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_item.found) |-> (out_item.dist_sq == '0))
		else $error("empty search gave a distance");
	a_wall_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_item.found) |-> (32'(out_item.nearest_wall) < MaxWalls))
		else $error("wall index out of range");
`endif

endmodule

`default_nettype wire

/* src/npws_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npws_ram: generic single-port write, single-port read memory
// Registered read data, no reset on the storage.
// ----------------------------------------------------------------------------
module npws_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/npws_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npws_div: iterative unsigned restoring divider
// Produces floor(num * 65536 / den), one quotient bit per cycle, saturated to 65536.
// ----------------------------------------------------------------------------
module npws_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] num,   // dot, taken as unsigned, shifted left by 16 inside
	input  wire logic [32:0] den,   // len_sq; zero saturates the quotient
	output logic             done,
	output logic [16:0]      quot
);

	// The quotient of dot*65536/len_sq needs at most 17 bits once it is known
	// not to exceed 65536; a dot at least len_sq saturates at once.
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [48:0] rem_q;
	logic [32:0] num_q;
	logic [32:0] den_q;
	logic [16:0] quot_q;
	logic        sat_q;
	logic [49:0] trial;

	assign trial = {rem_q, num_q[32]} - {17'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
			end else if (busy_q) begin
				if (cnt_q == 6'd1 || sat_q) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	// Dividend is num << 16, fed one bit a step from the top; 49 steps.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			num_q  <= num;
			den_q  <= den;
			quot_q <= '0;
			sat_q  <= (num >= den);
		end else if (busy_q && !sat_q) begin
			if (!trial[49]) begin
				rem_q  <= trial[48:0];
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[47:0], num_q[32]};
				quot_q <= {quot_q[15:0], 1'b0};
			end
			num_q <= {num_q[31:0], 1'b0};
		end
	end

	assign quot = sat_q ? 17'd65536 : quot_q;

endmodule

`default_nettype wire

/* src/npws_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npws_dp: projection and compare datapath
// Projects the query point onto one wall per pass and keeps the best result.
// ----------------------------------------------------------------------------
module npws_dp
	import npws_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire npws_cmd_t          cmd,
	input  wire logic [5:0]         wall_idx,
	input  wire logic signed [15:0] qx_in,
	input  wire logic signed [15:0] qy_in,
	input  wire wall_t              rdata,
	output npws_sts_t               sts,
	output out_item_t               best
);

	logic signed [15:0] qx_q, qy_q;
	wall_t              w_q;
	logic signed [16:0] dx_q, dy_q, ox_q, oy_q;
	logic signed [33:0] pxx_q, pyy_q, pdx_q, pdy_q;
	logic [32:0]        len_sq_q;
	logic signed [34:0] dot_q;
	logic               degen_q;
	logic               div_done;
	logic [16:0]        quot;
	logic signed [34:0] tdx_q, tdy_q;
	logic signed [16:0] ex_q, ey_q;
	logic signed [15:0] px_q, py_q;
	logic [33:0]        ex2_q, ey2_q;
	logic [32:0]        d;
	logic               have_q;
	logic signed [15:0] best_x_q, best_y_q;
	logic [32:0]        best_d_q;
	logic [5:0]         best_w_q;

	npws_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (dot_q[32:0]),
		.den   (len_sq_q),
		.done  (div_done),
		.quot  (quot)
	);

	assign sts.div_done = div_done;

	assign d  = 33'(ex2_q + ey2_q);

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qx_q <= qx_in;
			qy_q <= qy_in;
		end
		if (cmd.read_data) begin
			w_q <= rdata;
		end
		if (cmd.step_diff) begin
			dx_q <= 17'(w_q.x2) - 17'(w_q.x1);
			dy_q <= 17'(w_q.y2) - 17'(w_q.y1);
			ox_q <= 17'(qx_q) - 17'(w_q.x1);
			oy_q <= 17'(qy_q) - 17'(w_q.y1);
		end
		if (cmd.step_prod) begin
			pxx_q <= dx_q * dx_q;
			pyy_q <= dy_q * dy_q;
			pdx_q <= ox_q * dx_q;
			pdy_q <= oy_q * dy_q;
		end
		if (cmd.step_sum) begin
			len_sq_q <= 33'(pxx_q + pyy_q);
			dot_q    <= 35'(pdx_q) + 35'(pdy_q);
			degen_q  <= (pxx_q == '0) && (pyy_q == '0);
		end
		if (cmd.step_tmul) begin
			if (degen_q || dot_q <= 0) begin
				tdx_q <= '0;
				tdy_q <= '0;
			end else begin
				tdx_q <= $signed({1'b0, quot}) * dx_q;
				tdy_q <= $signed({1'b0, quot}) * dy_q;
			end
		end
		// The floor shift by 16 is an arithmetic shift; the point always lies on
		// the wall, so the sum wraps back into range at 16 bits.
		if (cmd.step_point) begin
			px_q <= 16'(w_q.x1 + 16'(tdx_q >>> 16));
			py_q <= 16'(w_q.y1 + 16'(tdy_q >>> 16));
			ex_q <= 17'(16'(w_q.x1 + 16'(tdx_q >>> 16))) - 17'(qx_q);
			ey_q <= 17'(16'(w_q.y1 + 16'(tdy_q >>> 16))) - 17'(qy_q);
		end
		if (cmd.step_esq) begin
			ex2_q <= 34'(ex_q * ex_q);
			ey2_q <= 34'(ey_q * ey_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.load_query) begin
			have_q <= 1'b0;
		end else if (cmd.step_cmp) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			best_x_q <= qx_in;
			best_y_q <= qy_in;
			best_d_q <= '0;
			best_w_q <= '0;
		end else if (cmd.step_cmp && (!have_q || d < best_d_q)) begin
			best_x_q <= px_q;
			best_y_q <= py_q;
			best_d_q <= d;
			best_w_q <= wall_idx;
		end
	end

	assign best = '{best_x_q, best_y_q, best_d_q, best_w_q, have_q};

endmodule

`default_nettype wire

/* src/npws_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npws_ctrl: sequencer for queries
// Walks the wall table one entry at a time and steps the datapath.
// ----------------------------------------------------------------------------
module npws_ctrl
	import npws_pkg::*;
#(
	parameter int unsigned MaxWalls = DefMaxWalls
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [NumWallsW-1:0]        num_walls,
	input  wire npws_sts_t                   sts,
	output npws_cmd_t                        cmd,
	output logic [$clog2(MaxWalls+1)-1:0]    idx,
	output logic                             busy,
	output logic                             done
);

	localparam int unsigned IdxW = $clog2(MaxWalls + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_READ  = 4'd1;
	localparam logic [3:0] S_CAP   = 4'd2;
	localparam logic [3:0] S_DIFF  = 4'd3;
	localparam logic [3:0] S_PROD  = 4'd4;
	localparam logic [3:0] S_SUM   = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_TMUL  = 4'd7;
	localparam logic [3:0] S_POINT = 4'd8;
	localparam logic [3:0] S_ESQ   = 4'd9;
	localparam logic [3:0] S_CMP   = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0]      state_q;
	logic [IdxW-1:0] idx_q;
	logic [IdxW-1:0] n_q;
	logic [IdxW-1:0] n_sat;
	logic            div_armed;

	assign n_sat = (32'(num_walls) > MaxWalls) ? IdxW'(MaxWalls) : IdxW'(num_walls);
	assign idx   = idx_q;
	assign busy  = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						idx_q   <= '0;
						n_q     <= n_sat;
						state_q <= (n_sat == '0) ? S_DONE : S_READ;
					end
				end
				S_READ:  state_q <= S_CAP;
				S_CAP:   state_q <= S_DIFF;
				S_DIFF:  state_q <= S_PROD;
				S_PROD:  state_q <= S_SUM;
				S_SUM:   state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_TMUL;
					end
				end
				S_TMUL:  state_q <= S_POINT;
				S_POINT: state_q <= S_ESQ;
				S_ESQ:   state_q <= S_CMP;
				S_CMP: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == n_q) ? S_DONE : S_READ;
				end
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.load_query = (state_q == S_IDLE) && go;
		cmd.read_data  = (state_q == S_CAP);
		cmd.step_diff  = (state_q == S_DIFF);
		cmd.step_prod  = (state_q == S_PROD);
		cmd.step_sum   = (state_q == S_SUM);
		cmd.step_tmul  = (state_q == S_TMUL);
		cmd.step_point = (state_q == S_POINT);
		cmd.step_esq   = (state_q == S_ESQ);
		cmd.step_cmp   = (state_q == S_CMP);
		// The divider is started in the cycle after the sum step, once the sums are registered.
		cmd.div_start  = (state_q == S_DIV) && div_armed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_armed <= 1'b0;
		end else begin
			div_armed <= (state_q == S_SUM);
		end
	end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for nearest_point_on_wall_segments
// A directed table, a fill of every wall entry and random phases of wall
// writes and queries run against an in-bench nearest point predictor. The
// setting of num_walls changes between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import npws_pkg::*;

	typedef struct {
		logic [NumWallsW-1:0] nw;
		in_item_t             item;
		bit                   typed;
		out_item_t            want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_item_t             in_item;
	logic                 done;
	out_item_t            out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [NumWallsW-1:0] cfg_data;

	wall_t                walls [DefMaxWalls];
	logic [NumWallsW-1:0] nw_cur;
	out_item_t            pending_points [$];
	stim_row_t            directed_rows [$];
	int                   fail_count;
	int                   item_count;
	int                   query_count;
	int                   stall_cycles;

	nearest_point_on_wall_segments DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .done(done), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic out_item_t nearest_point(input in_item_t q);
		out_item_t r;
		longint dx, dy, len_sq, dot, t, px, py, ex, ey, d, best;
		int n;
		bit have;
		r.closest_x = q.query_x;
		r.closest_y = q.query_y;
		r.dist_sq = '0;
		r.nearest_wall = '0;
		r.found = 1'b0;
		have = 0;
		best = 0;
		n = (nw_cur > DefMaxWalls) ? DefMaxWalls : nw_cur;
		for (int i = 0; i < n; i++) begin
			dx = longint'(walls[i].x2) - longint'(walls[i].x1);
			dy = longint'(walls[i].y2) - longint'(walls[i].y1);
			len_sq = dx * dx + dy * dy;
			px = walls[i].x1;
			py = walls[i].y1;
			if (len_sq > 0) begin
				dot = (longint'(q.query_x) - longint'(walls[i].x1)) * dx +
				      (longint'(q.query_y) - longint'(walls[i].y1)) * dy;
				t = 0;
				if (dot > 0) begin
					t = (dot <<< 16) / len_sq;
					if (t > 65536) t = 65536;
				end
				// Arithmetic shift of a signed value is a floor division.
				px = px + ((t * dx) >>> 16);
				py = py + ((t * dy) >>> 16);
			end
			ex = px - longint'(q.query_x);
			ey = py - longint'(q.query_y);
			d = ex * ex + ey * ey;
			if (!have || d < best) begin
				have = 1;
				best = d;
				r.closest_x = px[15:0];
				r.closest_y = py[15:0];
				r.dist_sq = best[32:0];
				r.nearest_wall = i[5:0];
				r.found = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: rand_coord = 16'h7FFF;
			1: rand_coord = 16'h8000;
			2, 3: rand_coord = 16'($urandom_range(0, 2047)) - 16'd1024;
			default: rand_coord = 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_item(input bit query);
		in_item_t it;
		it = '0;
		it.wall_index = 6'($urandom_range(0, 63));
		it.func = query ? FUNC_QUERY : FUNC_WRITE;
		it.wall_x1 = rand_coord();
		it.wall_y1 = rand_coord();
		it.wall_x2 = rand_coord();
		it.wall_y2 = rand_coord();
		if ($urandom_range(0, 9) == 0) begin
			it.wall_x2 = it.wall_x1;
			it.wall_y2 = it.wall_y1;
		end
		it.query_x = rand_coord();
		it.query_y = rand_coord();
		return it;
	endfunction

	// Changes num_walls once every query has answered and any write has settled.
	task automatic set_num_walls(input logic [NumWallsW-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (pending_points.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		nw_cur = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		bit quiet;
		quiet = (item_count >= 300 && item_count < 500);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 22) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		item_count++;
		if (it.func == FUNC_QUERY) begin
			query_count++;
			pending_points.push_back(typed ? want : nearest_point(it));
		end else begin
			walls[it.wall_index] = '{it.wall_x1, it.wall_y1, it.wall_x2, it.wall_y2};
		end
	endtask

	task automatic add_row(input int nw, input logic f, input int idx,
			input int x1, input int y1, input int x2, input int y2,
			input int qx, input int qy, input bit typed,
			input int ex, input int ey, input longint ed, input int ew, input int ef);
		stim_row_t r;
		r.nw = nw[6:0];
		r.item = '0;
		r.item.func = f;
		r.item.wall_index = idx[5:0];
		r.item.wall_x1 = x1[15:0];
		r.item.wall_y1 = y1[15:0];
		r.item.wall_x2 = x2[15:0];
		r.item.wall_y2 = y2[15:0];
		r.item.query_x = qx[15:0];
		r.item.query_y = qy[15:0];
		r.typed = typed;
		r.want.closest_x = ex[15:0];
		r.want.closest_y = ey[15:0];
		r.want.dist_sq = ed[32:0];
		r.want.nearest_wall = ew[5:0];
		r.want.found = ef[0];
		directed_rows.push_back(r);
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (pending_points.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, out_item);
				fail_count++;
			end else begin
				if (out_item.closest_x !== pending_points[0].closest_x) begin
					$display("%0t: closest_x expected %0d actual %0d", $time,
						pending_points[0].closest_x, out_item.closest_x);
					fail_count++;
				end
				if (out_item.closest_y !== pending_points[0].closest_y) begin
					$display("%0t: closest_y expected %0d actual %0d", $time,
						pending_points[0].closest_y, out_item.closest_y);
					fail_count++;
				end
				if (out_item.dist_sq !== pending_points[0].dist_sq) begin
					$display("%0t: dist_sq expected %0d actual %0d", $time,
						pending_points[0].dist_sq, out_item.dist_sq);
					fail_count++;
				end
				if (out_item.nearest_wall !== pending_points[0].nearest_wall) begin
					$display("%0t: nearest_wall expected %0d actual %0d", $time,
						pending_points[0].nearest_wall, out_item.nearest_wall);
					fail_count++;
				end
				if (out_item.found !== pending_points[0].found) begin
					$display("%0t: found expected %0d actual %0d", $time,
						pending_points[0].found, out_item.found);
					fail_count++;
				end
				void'(pending_points.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= 20000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int nw_plan [10];
		int len_plan [10];
		in_item_t it;
		out_item_t none;
		nw_plan = '{1, 64, 2, 7, 127, 3, 0, 5, 64, 4};
		len_plan = '{150, 30, 150, 150, 30, 150, 100, 150, 30, 150};
		none = '0;
		fail_count = 0;
		item_count = 0;
		query_count = 0;
		stall_cycles = 0;
		nw_cur = '0;
		foreach (walls[i]) walls[i] = '0;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;

		// With no walls searched the query point comes back, found low.
		add_row(0, FUNC_QUERY, 0, 0, 0, 0, 0, 32767, 32767, 1, 32767, 32767, 0, 0, 0);
		add_row(0, FUNC_QUERY, 63, -1, -1, -1, -1, -32768, -32768, 1,
			-32768, -32768, 0, 0, 0);
		add_row(0, FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(0, FUNC_WRITE, 0, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, FUNC_WRITE, 1, 100, -50, 100, -50, -1, -1, 0, 0, 0, 0, 0, 0);
		add_row(0, FUNC_WRITE, 2, 0, 0, 160, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, FUNC_WRITE, 3, 0, 0, 160, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, FUNC_WRITE, 63, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(1, FUNC_QUERY, 0, 0, 0, 0, 0, -32768, -32768, 1,
			-32768, -32768, 0, 0, 1);
		add_row(1, FUNC_QUERY, 0, 0, 0, 0, 0, 32767, 32767, 1, 32767, 32767, 0, 0, 1);
		add_row(1, FUNC_QUERY, 0, 0, 0, 0, 0, 32767, -32768, 0, 0, 0, 0, 0, 0);
		add_row(1, FUNC_QUERY, 0, 0, 0, 0, 0, 12, -700, 0, 0, 0, 0, 0, 0);
		// A degenerate wall gives its first endpoint.
		add_row(2, FUNC_QUERY, 0, 0, 0, 0, 0, 100, -50, 1, 100, -50, 0, 1, 1);
		add_row(2, FUNC_QUERY, 0, 0, 0, 0, 0, 200, 300, 0, 0, 0, 0, 0, 0);
		add_row(3, FUNC_QUERY, 0, 0, 0, 0, 0, 80, 10, 0, 0, 0, 0, 0, 0);
		add_row(3, FUNC_QUERY, 0, 0, 0, 0, 0, 500, 0, 0, 0, 0, 0, 0, 0);
		add_row(3, FUNC_QUERY, 0, 0, 0, 0, 0, -300, 7, 0, 0, 0, 0, 0, 0);
		// Walls two and three are equal, so the tie goes to the lower index.
		add_row(4, FUNC_QUERY, 0, 0, 0, 0, 0, 80, 10, 1, 80, 0, 100, 2, 1);
		add_row(4, FUNC_QUERY, 0, 0, 0, 0, 0, 32767, -32768, 0, 0, 0, 0, 0, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].nw != nw_cur) set_num_walls(directed_rows[i].nw);
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		end

		// Every entry is written before a query can reach past the first four.
		for (int i = 0; i < DefMaxWalls; i++) begin
			it = rand_item(0);
			it.wall_index = i[5:0];
			send_item(it, 0, none);
		end

		foreach (nw_plan[p]) begin
			set_num_walls(nw_plan[p][6:0]);
			for (int k = 0; k < len_plan[p]; k++)
				send_item(rand_item($urandom_range(0, 1)), 0, none);
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d items, %0d of them queries, over num_walls settings 0 to 127.",
			item_count, query_count);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
src/npws_pkg.sv
src/npws_ram.sv
src/npws_div.sv
src/npws_dp.sv
src/npws_ctrl.sv
src/nearest_point_on_wall_segments.sv
tb/sv/tb_top.sv
